FILE: sv/tvcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvcl_pkg: shared types and constants of the line-numbering text filter
// Item and result structs, register indexes, job record and character codes.
// ----------------------------------------------------------------------------
package tvcl_pkg;

  localparam int NUMBER_DIGITS_DEF = 6;
  localparam int QUEUE_DEPTH_DEF   = 2;
  localparam int CFG_ADDR_W        = 3;
  localparam int CFG_DATA_W        = 1;

  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CTRL_OFS  = 8'd64;
  localparam logic [3:0] DIGIT_HI  = 4'h3;   // '0'..'9' are 0x30..0x39
  localparam logic [3:0] BCD_NINE  = 4'd9;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_NUMBER_ALL      = 3'd0,
    CFG_NUMBER_NONBLANK = 3'd1,
    CFG_SQUEEZE_BLANK   = 3'd2,
    CFG_SHOW_LINE_ENDS  = 3'd3,
    CFG_SHOW_TABS       = 3'd4,
    CFG_SHOW_NONPRINT   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic number_all_lines;
    logic number_nonblank_lines;
    logic squeeze_blank;
    logic show_line_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_of_run;
  } out_item_t;

  // One classified request: optional number prefix, then 1..4 rendered bytes.
  typedef struct packed {
    logic            numbered;
    logic [1:0]      len_m1;
    logic [3:0][7:0] bytes;
  } job_t;

endpackage

FILE: sv/tvcl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvcl_front: accepts raw bytes and classifies them into jobs
// Keeps the line state and a BCD line counter, squeezes blank lines and
// builds the rendered byte sequence for the back end.
// ----------------------------------------------------------------------------
module tvcl_front import tvcl_pkg::*; #(
  parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cfg_t                            cfg,
  input  in_item_t                        item,
  input  logic                            accept,
  output logic                            job_push,
  output job_t                            job,
  output logic [NUMBER_DIGITS-1:0][3:0]   job_bcd
);

  logic                          at_line_start, at_line_start_next;
  logic                          blank_seen, blank_seen_next;
  logic [NUMBER_DIGITS-1:0][3:0] line_counter, line_counter_next;

  logic                          start_eff, blank_eff;
  logic [NUMBER_DIGITS-1:0][3:0] cnt_eff, cnt_inc;
  logic                          is_nl, is_tab, drop, numbered, all_nines, carry;
  logic [6:0]                    low7;
  logic                          is_ctl;
  logic [7:0]                    ctl_char;

  // file_start resets the line state ahead of the byte
  always_comb begin
    start_eff = item.file_start | at_line_start;
    blank_eff = ~item.file_start & blank_seen;
    cnt_eff   = item.file_start ? '0 : line_counter;
    is_nl     = (item.char_in == CH_NL);
    is_tab    = (item.char_in == CH_TAB);
  end

  // saturating BCD increment
  always_comb begin
    all_nines = 1'b1;
    carry     = 1'b1;
    cnt_inc   = cnt_eff;
    for (int k = 0; k < NUMBER_DIGITS; k++) begin
      all_nines = all_nines & (cnt_eff[k] == BCD_NINE);
    end
    for (int k = 0; k < NUMBER_DIGITS; k++) begin
      if (carry) begin
        if (cnt_eff[k] == BCD_NINE) begin
          cnt_inc[k] = 4'd0;
        end else begin
          cnt_inc[k] = cnt_eff[k] + 4'd1;
          carry      = 1'b0;
        end
      end
    end
    if (all_nines) begin
      cnt_inc = cnt_eff;
    end
  end

  always_comb begin
    drop            = start_eff & cfg.squeeze_blank & is_nl & blank_eff;
    blank_seen_next = blank_eff;
    if (start_eff && cfg.squeeze_blank) begin
      blank_seen_next = is_nl;
    end
    if (is_nl) begin
      numbered = start_eff & cfg.number_all_lines & ~cfg.number_nonblank_lines;
    end else begin
      numbered = start_eff & (cfg.number_all_lines | cfg.number_nonblank_lines);
    end
    numbered           = numbered & ~drop;
    line_counter_next  = numbered ? cnt_inc : cnt_eff;
    at_line_start_next = drop ? 1'b1 : is_nl;
  end

  // rendering of the byte itself
  always_comb begin
    low7     = item.char_in[6:0];
    is_ctl   = (low7 < 7'd32) || (low7 == CH_DEL[6:0]);
    ctl_char = (low7 == CH_DEL[6:0]) ? CH_QMARK : ({1'b0, low7} + CTRL_OFS);
    job.bytes  = '0;
    job.len_m1 = 2'd0;
    priority if (is_nl) begin
      if (cfg.show_line_ends) begin
        job.bytes[0] = CH_DOLLAR;
        job.bytes[1] = CH_NL;
        job.len_m1   = 2'd1;
      end else begin
        job.bytes[0] = CH_NL;
      end
    end else if (is_tab) begin
      if (cfg.show_tabs) begin
        job.bytes[0] = CH_CARET;
        job.bytes[1] = CH_I;
        job.len_m1   = 2'd1;
      end else begin
        job.bytes[0] = CH_TAB;
      end
    end else if (cfg.show_nonprinting) begin
      unique case ({item.char_in[7], is_ctl})
        2'b11: begin
          job.bytes  = {ctl_char, CH_CARET, CH_DASH, CH_M};
          job.len_m1 = 2'd3;
        end
        2'b10: begin
          job.bytes[0] = CH_M;
          job.bytes[1] = CH_DASH;
          job.bytes[2] = {1'b0, low7};
          job.len_m1   = 2'd2;
        end
        2'b01: begin
          job.bytes[0] = CH_CARET;
          job.bytes[1] = ctl_char;
          job.len_m1   = 2'd1;
        end
        default: begin
          job.bytes[0] = item.char_in;
        end
      endcase
    end else begin
      job.bytes[0] = item.char_in;
    end
    job.numbered = numbered;
  end

  assign job_bcd  = line_counter_next;
  assign job_push = accept & ~drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start <= 1'b1;
      blank_seen    <= 1'b0;
      line_counter  <= '0;
    end else if (accept) begin
      at_line_start <= at_line_start_next;
      blank_seen    <= blank_seen_next;
      line_counter  <= line_counter_next;
    end
  end

endmodule

FILE: sv/tvcl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvcl_queue: short job queue between front and back
// Register-based FIFO; full and empty come straight from the fill count.
// ----------------------------------------------------------------------------
module tvcl_queue import tvcl_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [DEPTH-1:0][WIDTH-1:0] mem;
  logic [AW-1:0]               wptr, rptr;
  logic [AW:0]                 count;
  logic                        do_wr, do_rd;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr & ~full;
  assign do_rd = rd & ~empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + AW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + AW'(1);
      end
      count <= count + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

endmodule

FILE: sv/tvcl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvcl_back: expands jobs into output bytes
// Walks the number prefix (digits, tab) and the rendered bytes one per cycle
// into an output register, as long as that register is free or being popped.
// ----------------------------------------------------------------------------
module tvcl_back import tvcl_pkg::*; #(
  parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_valid,
  input  job_t                          job,
  input  logic [NUMBER_DIGITS-1:0][3:0] job_bcd,
  output logic                          job_pop,
  output out_item_t                     result,
  output logic                          empty,
  input  logic                          pop
);

  localparam int PW = $clog2(NUMBER_DIGITS + 5);

  logic [PW-1:0]          pos;
  logic                   out_valid, emit, in_digits, at_tab, last;
  logic [PW-1:0]          rel_full;
  logic [1:0]             rel;
  logic [NUMBER_DIGITS:0] nz;
  logic [7:0]             digit_char, cur_byte;

  // leading zeros print as spaces, the units digit always prints
  always_comb begin
    nz[NUMBER_DIGITS] = 1'b0;
    for (int k = NUMBER_DIGITS - 1; k >= 0; k--) begin
      nz[k] = nz[k+1] | (job_bcd[k] != 4'd0);
    end
    digit_char = CH_SPACE;
    for (int k = 0; k < NUMBER_DIGITS; k++) begin
      if (pos == PW'(NUMBER_DIGITS - 1 - k)) begin
        digit_char = (k != 0 && !nz[k]) ? CH_SPACE : {DIGIT_HI, job_bcd[k]};
      end
    end
  end

  always_comb begin
    in_digits = job.numbered & (pos < PW'(NUMBER_DIGITS));
    at_tab    = job.numbered & (pos == PW'(NUMBER_DIGITS));
    rel_full  = job.numbered ? pos - PW'(NUMBER_DIGITS + 1) : pos;
    rel       = rel_full[1:0];
    last      = ~in_digits & ~at_tab & (rel == job.len_m1);
    priority if (in_digits) begin
      cur_byte = digit_char;
    end else if (at_tab) begin
      cur_byte = CH_TAB;
    end else begin
      cur_byte = job.bytes[rel];
    end
  end

  assign emit    = job_valid & (~out_valid | pop);
  assign job_pop = emit & last;
  assign empty   = ~out_valid;

  always_ff @(posedge clk) begin
    if (emit) begin
      result.char_out    <= cur_byte;
      result.last_of_run <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        pos       <= last ? '0 : pos + PW'(1);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/text_visible_char_line_number_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_visible_char_line_number_filter: line-numbering visible-char filter
// Squeezes blank lines, prefixes line numbers, marks line ends with $ and renders
// tabs and controls in caret notation, high bytes with an M- prefix.
// ----------------------------------------------------------------------------
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------
//  input     | push / full        | item   : char_in[7:0], file_start
//  result    | empty / pop        | result : char_out[7:0], last_of_run
//  config    | cfg_we             | cfg_addr[2:0], cfg_wdata[0]
//
//  Each request yields 1 to NUMBER_DIGITS+5 result bytes, one per cycle while pop
//  keeps the result register free, paced by the back end's byte sequencer;
//  squeezed blank lines yield none. A request's first byte passes the job queue and the result register.
//  Synchronous reset clears config, line state, counter, queue and output valid.
//  full rises when the job queue holds QUEUE_DEPTH jobs (two by default); a stalled
//  pop holds the result register and, behind it, the queue.
//
module text_visible_char_line_number_filter import tvcl_pkg::*; #(
  parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              item,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             result,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int BCD_W = 4 * NUMBER_DIGITS;
  localparam int JOB_W = $bits(job_t) + BCD_W;

  cfg_t                          cfg;
  logic                          accept, job_push, q_empty, job_pop;
  job_t                          job_in, job_out;
  logic [NUMBER_DIGITS-1:0][3:0] bcd_in, bcd_out;
  logic [JOB_W-1:0]              q_wdata, q_rdata;

  // configuration registers, one bit each
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_addr))
        CFG_NUMBER_ALL:      cfg.number_all_lines      <= cfg_wdata[0];
        CFG_NUMBER_NONBLANK: cfg.number_nonblank_lines <= cfg_wdata[0];
        CFG_SQUEEZE_BLANK:   cfg.squeeze_blank         <= cfg_wdata[0];
        CFG_SHOW_LINE_ENDS:  cfg.show_line_ends        <= cfg_wdata[0];
        CFG_SHOW_TABS:       cfg.show_tabs             <= cfg_wdata[0];
        CFG_SHOW_NONPRINT:   cfg.show_nonprinting      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign accept = push & ~full;

  // front end: line state, squeeze, numbering decision, rendering
  tvcl_front #(
    .NUMBER_DIGITS (NUMBER_DIGITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .item     (item),
    .accept   (accept),
    .job_push (job_push),
    .job      (job_in),
    .job_bcd  (bcd_in)
  );

  assign q_wdata = {bcd_in, job_in};

  // jobs wait here so front and back stall on their own
  tvcl_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (job_push),
    .wdata (q_wdata),
    .full  (full),
    .rd    (job_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign job_out = q_rdata[$bits(job_t)-1:0];
  assign bcd_out = q_rdata[JOB_W-1:$bits(job_t)];

  // back end: byte sequencer and output register
  tvcl_back #(
    .NUMBER_DIGITS (NUMBER_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (~q_empty),
    .job       (job_out),
    .job_bcd   (bcd_out),
    .job_pop   (job_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

FILE: sv/tvcl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvcl_checker: port-level checks of the text filter
// Reset state, queue/result relation and result hold under stall.
// ----------------------------------------------------------------------------
module tvcl_checker import tvcl_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t result
);

  // after reset nothing is pending and input is open
  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("not idle after reset");

  // a full job queue implies the back end already has a result waiting
  a_full_has_result: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("queue full while result side empty");

  a_result_stays: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result withdrawn without pop");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(result))
    else $error("result changed while stalled");

endmodule

bind text_visible_char_line_number_filter tvcl_checker u_tvcl_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
